### hw/rtl/rcib_pkg.sv
// ---------------------------------------------------------------------------
// rcib_pkg
// Shared constants, codes and types for the radio-control serial frame
// receiver.
// ---------------------------------------------------------------------------
package rcib_pkg;

    // Frame layout.
    localparam int unsigned FRAME_LEN   = 32;
    localparam int unsigned POS_W       = $clog2(FRAME_LEN);
    localparam int unsigned CSUM_POS    = 30;
    localparam int unsigned CH_BASE     = 2;
    localparam logic [7:0]  HDR0        = 8'h20;
    localparam logic [7:0]  HDR1        = 8'h40;
    localparam logic [15:0] SUM_INIT    = 16'hFFFF;

    // Channels.
    localparam int unsigned CHANNELS_DEF = 14;
    localparam int unsigned CH_W         = 4;

    // Counters.
    localparam int unsigned CNT_W = 32;

    // Normalisation: (raw - 1500) * 32768 / 500, done as mag * 8192 / 125.
    // The quotient by 125 is a multiply by a rounded-up reciprocal of
    // 2^29 / 125, which is exact for all dividends below 2^22.
    localparam int unsigned CENTRE     = 1500;
    localparam int unsigned SPAN       = 500;
    localparam int unsigned MAG_W      = 9;
    localparam int unsigned RECIP_SH   = 29;
    localparam int unsigned RECIP_DIV  = 125;
    localparam int unsigned RECIP_W    = 23;
    localparam int unsigned NORM_MUL   = ((1 << RECIP_SH) + RECIP_DIV - 1) / RECIP_DIV;
    localparam int unsigned PROD_W     = MAG_W + RECIP_W;
    localparam int unsigned NORM_RSH   = RECIP_SH - 13;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_RST  = 16'd100;
    localparam logic [14:0] DEADBAND_RST = 15'd1966;

    // Input commands.
    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_LINE_ERR = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SYNC     = 2'd0;
    localparam logic [1:0] KIND_CHECKSUM = 2'd1;
    localparam logic [1:0] KIND_CHANNEL  = 2'd2;
    localparam logic [1:0] KIND_FAILSAFE = 2'd3;

    // Configuration register indexes.
    localparam int unsigned  REG_IDX_W    = 2;
    localparam logic [1:0]   REG_TIMEOUT  = 2'd0;
    localparam logic [1:0]   REG_DEADBAND = 2'd1;

    // Write request into the frame store.
    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

### hw/rtl/rcib_in_if.sv
// ---------------------------------------------------------------------------
// rcib_in_if
// Input channel: one command with an optional received byte per request.
// ---------------------------------------------------------------------------
interface rcib_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

### hw/rtl/rcib_out_if.sv
// ---------------------------------------------------------------------------
// rcib_out_if
// Result channel: one decoded result with the counter snapshot per request.
// ---------------------------------------------------------------------------
interface rcib_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         channel_index;
    logic [15:0]        raw_value;
    logic signed [15:0] normalized;
    logic               last;
    logic [31:0]        sync_errors;
    logic [31:0]        checksum_errors;
    logic [31:0]        valid_frames;

    modport source (output valid, output kind, output channel_index, output raw_value,
                    output normalized, output last, output sync_errors,
                    output checksum_errors, output valid_frames, input ready);
    modport sink   (input valid, input kind, input channel_index, input raw_value,
                    input normalized, input last, input sync_errors,
                    input checksum_errors, input valid_frames, output ready);
endinterface

### hw/rtl/rcib_cfg_if.sv
// ---------------------------------------------------------------------------
// rcib_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface rcib_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/rcib_frame_mem.sv
// ---------------------------------------------------------------------------
// rcib_frame_mem
// Frame store: one write port and two read ports with registered read data.
// ---------------------------------------------------------------------------
module rcib_frame_mem (
    input  logic                       clk,
    input  rcib_pkg::mem_wr_t          wr,
    input  logic [rcib_pkg::POS_W-1:0] rd_addr_a,
    input  logic [rcib_pkg::POS_W-1:0] rd_addr_b,
    output logic [7:0]                 rd_data_a,
    output logic [7:0]                 rd_data_b
);
    import rcib_pkg::*;

    logic [7:0] mem [FRAME_LEN];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### hw/rtl/rcib_norm.sv
// ---------------------------------------------------------------------------
// rcib_norm
// Two-stage channel normaliser: centre, clamp, scale to Q1.15, deadband.
// ---------------------------------------------------------------------------
module rcib_norm (
    input  logic               clk,
    input  logic [15:0]        raw,
    input  logic [14:0]        deadband,
    output logic signed [15:0] norm
);
    import rcib_pkg::*;

    logic signed [16:0]  diff;
    logic                neg;
    logic [16:0]         mag_full;
    logic [PROD_W-1:0]   prod_reg;
    logic                hi_reg;
    logic                lo_reg;
    logic                neg_reg;
    logic [15:0]         q_mag;
    logic [16:0]         out_mag;
    logic signed [15:0]  q_val;

    assign diff     = $signed({1'b0, raw}) - $signed(17'(CENTRE));
    assign neg      = diff[16];
    assign mag_full = neg ? 17'(-diff) : 17'(diff);

    // Stage one: range flags and the reciprocal product.
    always_ff @(posedge clk)
    begin
        hi_reg   <= (diff >= $signed(17'(SPAN)));
        lo_reg   <= (diff <= -$signed(17'(SPAN)));
        neg_reg  <= neg;
        prod_reg <= PROD_W'(mag_full[MAG_W-1:0]) * PROD_W'(RECIP_W'(NORM_MUL));
    end

    assign q_mag = prod_reg[PROD_W-1:NORM_RSH];

    always_comb
    begin
        if (hi_reg)
        begin
            q_val   = 16'sh7FFF;
            out_mag = 17'h07FFF;
        end
        else if (lo_reg)
        begin
            q_val   = 16'sh8000;
            out_mag = 17'h08000;
        end
        else
        begin
            q_val   = neg_reg ? -$signed(q_mag) : $signed(q_mag);
            out_mag = {1'b0, q_mag};
        end
    end

    // Stage two: deadband and result register.
    always_ff @(posedge clk)
    begin
        norm <= (out_mag < {2'b00, deadband}) ? 16'sh0000 : q_val;
    end

endmodule

### hw/rtl/rc_ibus_frame_receiver.sv
// ---------------------------------------------------------------------------
// rc_ibus_frame_receiver
// Radio-control serial frame receiver: header sync, checksum, channel
// decoding with Q1.15 normalisation, failsafe timer and error counters.
//
//   Channel  Dir   Handshake      Payload
//   stream   in    valid/ready    command, rx_byte
//   result   out   valid/ready    kind, channel_index, raw_value, normalized,
//                                 last, sync_errors, checksum_errors,
//                                 valid_frames
//   cfg      in    valid/ready    index, data (always ready)
//
// A byte or tick without a result leaves the sequencer idle. One with a single result
// passes through an emit state that waits for the result register to drain.
// After the closing byte of a frame the sequencer compares the checksum with a
// frame store read, then per channel runs a store read, two normaliser stages
// and the result register load, waiting there while the result register is full.
// Reset clears control state and counters; the frame store has no clear.
// A waiting result does not hold the next request back once the sequencer
// has returned to idle.
// ---------------------------------------------------------------------------
module rc_ibus_frame_receiver #(
    parameter int unsigned CHANNELS = rcib_pkg::CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rcib_in_if.sink     stream,
    rcib_out_if.source  result,
    rcib_cfg_if.sink    cfg
);
    import rcib_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EMIT1 = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_W1    = 3'd4;
    localparam logic [2:0] S_W2    = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    logic [2:0]        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       sum_reg, sum_next;
    logic [15:0]       sum_base;
    logic [CNT_W-1:0]  sync_cnt_reg, sync_cnt_next;
    logic [CNT_W-1:0]  csum_cnt_reg, csum_cnt_next;
    logic [CNT_W-1:0]  frame_cnt_reg, frame_cnt_next;
    logic              armed_reg, armed_next;
    logic [15:0]       ms_reg, ms_next;
    logic [1:0]        pend_kind_reg, pend_kind_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [7:0]        csum_hi_reg, csum_hi_next;
    logic [15:0]       timeout_reg;
    logic [14:0]       deadband_reg;

    logic              out_valid_reg, out_valid_next;
    logic              load;
    logic [1:0]        kind_next;
    logic [CH_W-1:0]   ch_out_next;
    logic [15:0]       raw_next;
    logic signed [15:0] norm_next;
    logic              last_next;
    logic [1:0]        kind_reg;
    logic [CH_W-1:0]   ch_out_reg;
    logic [15:0]       raw_reg;
    logic signed [15:0] norm_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  sync_out_reg, csum_out_reg, frame_out_reg;

    logic              accept;
    logic              slot_free;
    mem_wr_t           wr;
    logic [POS_W-1:0]  even_addr;
    logic [POS_W-1:0]  rd_addr_a, rd_addr_b;
    logic [7:0]        rd_data_a, rd_data_b;
    logic signed [15:0] norm_val;

    assign stream.ready = (state_reg == S_IDLE);
    assign accept       = stream.valid && stream.ready;
    assign slot_free    = !out_valid_reg || result.ready;

    // Channel i sits at bytes 2+2i (low) and 3+2i (high); while idle, port A
    // looks at the low checksum byte so it is ready when the frame closes.
    assign even_addr = POS_W'(CH_BASE) + POS_W'({ch_reg, 1'b0});
    assign rd_addr_a = (state_reg == S_IDLE) ? POS_W'(CSUM_POS) : even_addr;
    assign rd_addr_b = {even_addr[POS_W-1:1], 1'b1};

    assign sum_base  = (pos_reg == '0) ? SUM_INIT : sum_reg;

    rcib_frame_mem u_mem (
        .clk       (clk),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    rcib_norm u_norm (
        .clk      (clk),
        .raw      ({rd_data_b, rd_data_a}),
        .deadband (deadband_reg),
        .norm     (norm_val)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        sync_cnt_next  = sync_cnt_reg;
        csum_cnt_next  = csum_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        armed_next     = armed_reg;
        ms_next        = ms_reg;
        pend_kind_next = pend_kind_reg;
        ch_next        = ch_reg;
        csum_hi_next   = csum_hi_reg;
        wr             = '0;
        load           = 1'b0;
        kind_next      = pend_kind_reg;
        ch_out_next    = '0;
        raw_next       = '0;
        norm_next      = '0;
        last_next      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (stream.command)
                        CMD_BYTE:
                        begin
                            if (pos_reg == POS_W'(0) && stream.rx_byte != HDR0)
                            begin
                                sync_cnt_next  = sat_inc(sync_cnt_reg);
                                pend_kind_next = KIND_SYNC;
                                state_next     = S_EMIT1;
                            end
                            else if (pos_reg == POS_W'(1) && stream.rx_byte != HDR1)
                            begin
                                // A stray header byte in second place opens a new frame.
                                sync_cnt_next  = sat_inc(sync_cnt_reg);
                                pend_kind_next = KIND_SYNC;
                                state_next     = S_EMIT1;
                                if (stream.rx_byte == HDR0)
                                begin
                                    wr.we    = 1'b1;
                                    wr.addr  = '0;
                                    wr.data  = stream.rx_byte;
                                    sum_next = SUM_INIT - {8'h00, stream.rx_byte};
                                    pos_next = POS_W'(1);
                                end
                                else
                                begin
                                    sum_next = SUM_INIT;
                                    pos_next = '0;
                                end
                            end
                            else
                            begin
                                wr.we    = 1'b1;
                                wr.addr  = pos_reg;
                                wr.data  = stream.rx_byte;
                                sum_next = (pos_reg < POS_W'(CSUM_POS))
                                           ? sum_base - {8'h00, stream.rx_byte}
                                           : sum_base;
                                pos_next = pos_reg + 1'b1;
                                if (pos_reg == POS_W'(FRAME_LEN - 1))
                                begin
                                    csum_hi_next = stream.rx_byte;
                                    state_next   = S_CHECK;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (armed_reg)
                            begin
                                if (ms_reg >= timeout_reg)
                                begin
                                    armed_next     = 1'b0;
                                    pend_kind_next = KIND_FAILSAFE;
                                    state_next     = S_EMIT1;
                                end
                                else
                                begin
                                    ms_next = ms_reg + 1'b1;
                                end
                            end
                        end
                        CMD_LINE_ERR:
                        begin
                            pos_next = '0;
                            sum_next = SUM_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EMIT1:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                sum_next = SUM_INIT;
                if ({csum_hi_reg, rd_data_a} != sum_reg)
                begin
                    csum_cnt_next  = sat_inc(csum_cnt_reg);
                    pend_kind_next = KIND_CHECKSUM;
                    state_next     = S_EMIT1;
                end
                else
                begin
                    frame_cnt_next = sat_inc(frame_cnt_reg);
                    armed_next     = 1'b1;
                    ms_next        = '0;
                    ch_next        = '0;
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_W1;
            end
            S_W1:
            begin
                state_next = S_W2;
            end
            S_W2:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                kind_next   = KIND_CHANNEL;
                ch_out_next = ch_reg;
                raw_next    = {rd_data_b, rd_data_a};
                norm_next   = norm_val;
                last_next   = (ch_reg == CH_LAST);
                if (slot_free)
                begin
                    load = 1'b1;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            sum_reg       <= SUM_INIT;
            sync_cnt_reg  <= '0;
            csum_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            armed_reg     <= 1'b0;
            ms_reg        <= '0;
            pend_kind_reg <= KIND_SYNC;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            sync_cnt_reg  <= sync_cnt_next;
            csum_cnt_reg  <= csum_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            armed_reg     <= armed_next;
            ms_reg        <= ms_next;
            pend_kind_reg <= pend_kind_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        csum_hi_reg <= csum_hi_next;
        if (load)
        begin
            kind_reg      <= kind_next;
            ch_out_reg    <= ch_out_next;
            raw_reg       <= raw_next;
            norm_reg      <= norm_next;
            last_reg      <= last_next;
            sync_out_reg  <= sync_cnt_reg;
            csum_out_reg  <= csum_cnt_reg;
            frame_out_reg <= frame_cnt_reg;
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RST;
            deadband_reg <= DEADBAND_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg.data;
            end
            else if (cfg.index == REG_DEADBAND)
            begin
                deadband_reg <= cfg.data[14:0];
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.kind            = kind_reg;
    assign result.channel_index   = ch_out_reg;
    assign result.raw_value       = raw_reg;
    assign result.normalized      = norm_reg;
    assign result.last            = last_reg;
    assign result.sync_errors     = sync_out_reg;
    assign result.checksum_errors = csum_out_reg;
    assign result.valid_frames    = frame_out_reg;

    // The closing byte of a frame always leads to the checksum test.
    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stream.command == CMD_BYTE && pos_reg == POS_W'(FRAME_LEN - 1))
        |=> (state_reg == S_CHECK && pos_reg == '0))
        else $error("frame close did not reach checksum test");

    // Channel emission never runs past the configured channel count.
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_EMIT) |-> (ch_reg <= CH_LAST))
        else $error("channel index out of range");

    // Counters only ever climb.
    a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (sync_cnt_reg >= $past(sync_cnt_reg)
                  && csum_cnt_reg >= $past(csum_cnt_reg)
                  && frame_cnt_reg >= $past(frame_cnt_reg)))
        else $error("error or frame counter went backwards");

    // A good checksum arms the link with a fresh timer.
    a_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && {csum_hi_reg, rd_data_a} == sum_reg)
        |=> (armed_reg && ms_reg == '0 && state_reg == S_RD))
        else $error("good frame did not arm the link");

endmodule

### tb/tb_rc_ibus_frame_receiver.sv
// ---------------------------------------------------------------------------
// tb_rc_ibus_frame_receiver
// Self-checking bench for the radio-control serial frame receiver. Requests
// (bytes, millisecond ticks, line errors, ignored commands) are driven with random gaps, and
// every request that is taken is run through a cycle-free decoder kept in
// the bench. Each decoded result that the block returns is compared with the
// oldest one predicted. The run covers header faults, good and corrupted
// frames, cut frames, failsafe timeouts and several timeout and deadband
// settings.
// ---------------------------------------------------------------------------
module tb_rc_ibus_frame_receiver;
    import rcib_pkg::*;

    localparam logic [1:0] CMD_IGNORED   = 2'd3;
    localparam int         SETTLE_CYCLES = 2 + 5 * CHANNELS_DEF + 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic [CH_W-1:0]    channel_index;
        logic [15:0]        raw_value;
        logic signed [15:0] normalized;
        logic               last;
        logic [CNT_W-1:0]   sync_errors;
        logic [CNT_W-1:0]   checksum_errors;
        logic [CNT_W-1:0]   valid_frames;
    } decoded_result_t;

    class ibus_decode_tracker;
        logic [15:0]      timeout_ms;
        logic [14:0]      deadband;
        int unsigned      position;
        logic [7:0]       frame_bytes [FRAME_LEN];
        logic [15:0]      running_sum;
        logic [CNT_W-1:0] sync_count;
        logic [CNT_W-1:0] checksum_count;
        logic [CNT_W-1:0] frame_count;
        bit               armed;
        logic [15:0]      ms_idle;
        decoded_result_t  pending_results [$];
        int unsigned      failures;
        int unsigned      results_seen;
        int unsigned      channels_seen;
        int unsigned      failsafes_seen;

        function new();
            timeout_ms     = TIMEOUT_RST;
            deadband       = DEADBAND_RST;
            position       = 0;
            running_sum    = SUM_INIT;
            sync_count     = '0;
            checksum_count = '0;
            frame_count    = '0;
            armed          = 1'b0;
            ms_idle        = '0;
            failures       = 0;
            results_seen   = 0;
            channels_seen  = 0;
            failsafes_seen = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void write_register(logic [1:0] index, logic [15:0] value);
            if (index == REG_TIMEOUT)
                timeout_ms = value;
            else if (index == REG_DEADBAND)
                deadband = value[14:0];
        endfunction

        // (raw - 1500) / 500 in Q1.15, saturated, truncated toward zero, then deadbanded.
        function logic signed [15:0] scale_channel(logic [15:0] raw);
            int diff;
            int q;
            int mag;
            diff = int'(raw) - 1500;
            if (diff >= 500)
                q = 32767;
            else if (diff <= -500)
                q = -32768;
            else
            begin
                mag = (diff < 0) ? -diff : diff;
                mag = (mag * 32768) / 500;
                q = (diff < 0) ? -mag : mag;
            end
            mag = (q < 0) ? -q : q;
            if (mag < int'(deadband))
                q = 0;
            return q[15:0];
        endfunction

        function void push_result(logic [1:0] kind, logic [CH_W-1:0] ch, logic [15:0] raw,
                                  logic signed [15:0] norm);
            decoded_result_t r;
            r.kind            = kind;
            r.channel_index   = ch;
            r.raw_value       = raw;
            r.normalized      = norm;
            r.last            = 1'b0;
            r.sync_errors     = sync_count;
            r.checksum_errors = checksum_count;
            r.valid_frames    = frame_count;
            pending_results.push_back(r);
        endfunction

        function void close_frame();
            logic [15:0] carried_sum;
            logic [15:0] raw;
            if (frame_bytes[0] != HDR0 || frame_bytes[1] != HDR1)
            begin
                sync_count = bump(sync_count);
                push_result(KIND_SYNC, '0, '0, '0);
                return;
            end
            carried_sum = {frame_bytes[31], frame_bytes[30]};
            if (running_sum != carried_sum)
            begin
                checksum_count = bump(checksum_count);
                push_result(KIND_CHECKSUM, '0, '0, '0);
                return;
            end
            frame_count = bump(frame_count);
            armed = 1'b1;
            ms_idle = '0;
            for (int i = 0; i < CHANNELS_DEF; i++)
            begin
                raw = {frame_bytes[3 + 2 * i], frame_bytes[2 + 2 * i]};
                push_result(KIND_CHANNEL, i[CH_W-1:0], raw, scale_channel(raw));
            end
        endfunction

        function void take_byte(logic [7:0] b);
            if (position == 0 && b != HDR0)
            begin
                sync_count = bump(sync_count);
                push_result(KIND_SYNC, '0, '0, '0);
                return;
            end
            if (position == 1 && b != HDR1)
            begin
                // A second opening byte in place of the second header byte starts afresh.
                sync_count = bump(sync_count);
                position = 0;
                running_sum = SUM_INIT;
                if (b == HDR0)
                begin
                    frame_bytes[0] = b;
                    running_sum = SUM_INIT - b;
                    position = 1;
                end
                push_result(KIND_SYNC, '0, '0, '0);
                return;
            end
            if (position == 0)
                running_sum = SUM_INIT;
            frame_bytes[position] = b;
            if (position < CSUM_POS)
                running_sum = running_sum - b;
            position++;
            if (position >= FRAME_LEN)
            begin
                position = 0;
                close_frame();
                running_sum = SUM_INIT;
            end
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] b);
            int unsigned before_count;
            before_count = pending_results.size();
            if (cmd == CMD_BYTE)
                take_byte(b);
            else if (cmd == CMD_TICK)
            begin
                if (armed)
                begin
                    if (ms_idle >= timeout_ms)
                    begin
                        armed = 1'b0;
                        push_result(KIND_FAILSAFE, '0, '0, '0);
                    end
                    else
                        ms_idle = ms_idle + 1'b1;
                end
            end
            else if (cmd == CMD_LINE_ERR)
            begin
                position = 0;
                running_sum = SUM_INIT;
            end
            if (pending_results.size() > before_count)
                pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        function void report(string what, decoded_result_t want, decoded_result_t got);
            failures++;
            if (failures <= 10)
            begin
                $display("MISMATCH (%s)", what);
                $display("  expected kind=%0d ch=%0d raw=%0d norm=%0d last=%0d se=%0d ce=%0d vf=%0d",
                         want.kind, want.channel_index, want.raw_value, want.normalized,
                         want.last, want.sync_errors, want.checksum_errors, want.valid_frames);
                $display("  actual   kind=%0d ch=%0d raw=%0d norm=%0d last=%0d se=%0d ce=%0d vf=%0d",
                         got.kind, got.channel_index, got.raw_value, got.normalized,
                         got.last, got.sync_errors, got.checksum_errors, got.valid_frames);
            end
        endfunction

        function void check_result(decoded_result_t got);
            decoded_result_t want;
            results_seen++;
            if (got.kind == KIND_CHANNEL)
                channels_seen++;
            if (got.kind == KIND_FAILSAFE)
                failsafes_seen++;
            if (pending_results.size() == 0)
            begin
                report("result with nothing outstanding", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind)
                report("kind", want, got);
            else if (got.channel_index != want.channel_index)
                report("channel_index", want, got);
            else if (got.raw_value != want.raw_value)
                report("raw_value", want, got);
            else if (got.normalized != want.normalized)
                report("normalized", want, got);
            else if (got.last != want.last)
                report("last", want, got);
            else if (got.sync_errors != want.sync_errors)
                report("sync_errors", want, got);
            else if (got.checksum_errors != want.checksum_errors)
                report("checksum_errors", want, got);
            else if (got.valid_frames != want.valid_frames)
                report("valid_frames", want, got);
        endfunction

        function void flag_leftovers();
            if (pending_results.size() != 0)
            begin
                $display("%0d expected results never arrived", pending_results.size());
                failures += pending_results.size();
                pending_results.delete();
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    bit          calm_stretch = 1'b0;
    int unsigned requests_sent = 0;

    ibus_decode_tracker decoder = new();

    rcib_in_if  byte_in ();
    rcib_out_if result_out ();
    rcib_cfg_if cfg_bus ();

    rc_ibus_frame_receiver uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_in),
        .result (result_out),
        .cfg    (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: take and check results, stall at random outside the calm stretch.
    initial
    begin
        decoded_result_t seen;
        result_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_out.valid && result_out.ready)
            begin
                seen.kind            = result_out.kind;
                seen.channel_index   = result_out.channel_index;
                seen.raw_value       = result_out.raw_value;
                seen.normalized      = result_out.normalized;
                seen.last            = result_out.last;
                seen.sync_errors     = result_out.sync_errors;
                seen.checksum_errors = result_out.checksum_errors;
                seen.valid_frames    = result_out.valid_frames;
                decoder.check_result(seen);
            end
            result_out.ready <= calm_stretch || ($urandom_range(99) >= 25);
        end
    end

    // Valid is left high after a request so that the next one can follow
    // without a gap; it only drops for an idle cycle or a pause.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] b);
        while (!calm_stretch && $urandom_range(99) < 25)
        begin
            byte_in.valid <= 1'b0;
            @(posedge clk);
        end
        byte_in.valid   <= 1'b1;
        byte_in.command <= cmd;
        byte_in.rx_byte <= b;
        do
            @(posedge clk);
        while (!byte_in.ready);
        decoder.note_request(cmd, b);
        if (cmd != CMD_IGNORED)
            requests_sent++;
    endtask

    task automatic drain_results();
        byte_in.valid <= 1'b0;
        while (decoder.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] timeout_val,
                                  input logic [15:0] deadband_val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= REG_TIMEOUT;
        cfg_bus.data  <= timeout_val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        decoder.write_register(REG_TIMEOUT, timeout_val);
        cfg_bus.index <= REG_DEADBAND;
        cfg_bus.data  <= deadband_val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        decoder.write_register(REG_DEADBAND, deadband_val);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_channel_word();
        case ($urandom_range(3))
            0:
            begin
                // Saturation, centre and default deadband boundaries.
                case ($urandom_range(14))
                    0:       return 16'd0;
                    1:       return 16'd999;
                    2:       return 16'd1000;
                    3:       return 16'd1001;
                    4:       return 16'd1499;
                    5:       return 16'd1500;
                    6:       return 16'd1501;
                    7:       return 16'd1999;
                    8:       return 16'd2000;
                    9:       return 16'd2001;
                    10:      return 16'd1529;
                    11:      return 16'd1530;
                    12:      return 16'd1470;
                    13:      return 16'd1471;
                    default: return 16'hFFFF;
                endcase
            end
            1:       return 16'($urandom_range(1000, 2000));
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1300, 1700));
        endcase
    endfunction

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_request(CMD_TICK, 8'($urandom));
    endtask

    task automatic send_frame(input bit allow_faults);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] check_word;
        logic [15:0] channel_word;
        int unsigned cut;
        frame[0] = HDR0;
        frame[1] = HDR1;
        for (int i = 0; i < CHANNELS_DEF; i++)
        begin
            channel_word = pick_channel_word();
            frame[2 + 2 * i] = channel_word[7:0];
            frame[3 + 2 * i] = channel_word[15:8];
        end
        check_word = SUM_INIT;
        for (int i = 0; i < CSUM_POS; i++)
            check_word = check_word - frame[i];
        if (allow_faults && $urandom_range(1) == 0)
            check_word = check_word ^ (16'd1 << $urandom_range(15));
        frame[30] = check_word[7:0];
        frame[31] = check_word[15:8];
        cut = (allow_faults && $urandom_range(3) == 0) ? $urandom_range(1, 31) : FRAME_LEN;
        // A line error first puts the receiver back at the start of a frame.
        if (!allow_faults || $urandom_range(4) != 0)
            send_request(CMD_LINE_ERR, 8'($urandom));
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(15) == 0)
                send_request(CMD_TICK, 8'($urandom));
            send_request(CMD_BYTE, frame[i]);
        end
        if (cut < FRAME_LEN)
            send_request(CMD_LINE_ERR, 8'($urandom));
    endtask

    task automatic send_noise();
        int unsigned pick;
        repeat ($urandom_range(1, 6))
        begin
            pick = $urandom_range(9);
            if (pick <= 2)
                send_request(CMD_BYTE, HDR0);
            else if (pick == 3)
                send_request(CMD_BYTE, HDR1);
            else if (pick == 4)
                send_request(CMD_IGNORED, 8'($urandom));
            else
                send_request(CMD_BYTE, 8'($urandom));
        end
    endtask

    // One frame, a short burst of line noise, then enough ticks to reach
    // the failsafe when the timeout is short.
    task automatic run_phase(input bit allow_faults);
        send_frame(allow_faults);
        send_noise();
        send_ticks((decoder.timeout_ms <= 8) ? decoder.timeout_ms + 2 : $urandom_range(1, 4));
    endtask

    task automatic run_header_cases();
        send_request(CMD_IGNORED, 8'hA5);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_LINE_ERR, 8'hFF);
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_BYTE, HDR1);
        send_request(CMD_BYTE, HDR0);
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, HDR0);
        send_request(CMD_BYTE, HDR0);
        send_request(CMD_BYTE, HDR1);
        send_request(CMD_LINE_ERR, 8'h5A);
        send_request(CMD_BYTE, HDR0);
        send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_BYTE, HDR0);
        send_request(CMD_BYTE, HDR1);
        send_request(CMD_LINE_ERR, 8'h00);
    endtask

    initial
    begin
        byte_in.valid   <= 1'b0;
        byte_in.command <= CMD_BYTE;
        byte_in.rx_byte <= 8'h00;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= REG_TIMEOUT;
        cfg_bus.data    <= 16'h0000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_header_cases();
        run_phase(1'b0);
        drain_results();

        write_settings(16'd1, 16'd0);
        run_phase(1'b1);
        drain_results();

        // Extreme settings with neither side idling.
        calm_stretch = 1'b1;
        write_settings(16'hFFFF, 16'h7FFF);
        run_phase(1'b0);
        drain_results();
        calm_stretch = 1'b0;

        write_settings(16'($urandom_range(2, 6)), {1'b1, 15'($urandom)});
        run_phase(1'b1);
        drain_results();

        decoder.flag_leftovers();
        $display("Ran %0d requests over four register settings; %0d results checked,",
                 requests_sent, decoder.results_seen);
        $display("%0d of them channel words and %0d failsafe events, %0d mismatches.",
                 decoder.channels_seen, decoder.failsafes_seen, decoder.failures);
        if (decoder.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out waiting for the receiver.");
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rcib_pkg.sv
hw/rtl/rcib_in_if.sv
hw/rtl/rcib_out_if.sv
hw/rtl/rcib_cfg_if.sv
hw/rtl/rcib_frame_mem.sv
hw/rtl/rcib_norm.sv
hw/rtl/rc_ibus_frame_receiver.sv
tb/tb_rc_ibus_frame_receiver.sv
